/* rtl/core/fcbm_pkg.sv */
package fcbm_pkg;

    localparam int NUM_BLOCKS_DEF = 4096;

    localparam int BLOCK_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        KIND_FORMAT = 2'd0,
        KIND_ALLOC  = 2'd1,
        KIND_FREE   = 2'd2,
        KIND_NEXT   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_BAD_BLK = 2'd2
    } status_t;

endpackage

/* rtl/core/fat_chain_block_manager_top.sv */
// next link reads one table entry; allocate scans one entry per cycle for a free block,
// free clears at most block_count chain entries, one per cycle; format reruns the clearing pass
// throughput: one transaction in flight; the next is taken while a finished result waits
// the link table sits in one memory with one write and one registered read port
// reset: synchronous active-low; afterwards a clearing pass runs through every table entry
// and no transaction is taken until it completes
module fat_chain_block_manager_top #(
    parameter int NUM_BLOCKS = fcbm_pkg::NUM_BLOCKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_kind,
    input  logic [fcbm_pkg::BLOCK_W-1:0]     s_block,
    input  logic [fcbm_pkg::COUNT_W-1:0]     s_block_count,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fcbm_pkg::BLOCK_W-1:0]     m_result_block,
    output logic                             m_is_end,
    output logic [fcbm_pkg::STATUS_W-1:0]    m_status,
    output logic [fcbm_pkg::COUNT_W-1:0]     m_freed_count
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_BLOCKS);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(NUM_BLOCKS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_LINK,
        S_FWALK,
        S_DONE
    } state_t;

    // link table
    logic [LINK_W-1:0] mem [NUM_BLOCKS];
    logic [LINK_W-1:0] rd_data_reg;
    logic [LINK_W-1:0] wr_hold_reg;
    logic              hit_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [LINK_W-1:0] eff;

    state_t                          state_reg, state_next;
    logic                            fmt_reg, fmt_next;
    logic [1:0]                      kind_reg, kind_next;
    logic [IDX_W-1:0]                blk_reg, blk_next;
    logic                            blk_zero_reg, blk_zero_next;
    logic                            blk_ok_reg, blk_ok_next;
    logic [fcbm_pkg::COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [fcbm_pkg::COUNT_W-1:0]    freed_reg, freed_next;
    logic [IDX_W-1:0]                cur_reg, cur_next;
    logic [IDX_W-1:0]                scan_reg, scan_next;
    logic [IDX_W-1:0]                clr_reg, clr_next;
    logic [fcbm_pkg::BLOCK_W-1:0]    res_reg, res_next;
    logic                            end_reg, end_next;
    logic [fcbm_pkg::STATUS_W-1:0]   st_reg, st_next;
    logic                            out_valid_reg, out_valid_next;
    logic [fcbm_pkg::BLOCK_W-1:0]    m_res_reg, m_res_next;
    logic                            m_end_reg, m_end_next;
    logic [fcbm_pkg::STATUS_W-1:0]   m_st_reg, m_st_next;
    logic [fcbm_pkg::COUNT_W-1:0]    m_freed_reg, m_freed_next;
    logic                            walk_step;

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_result_block = m_res_reg;
    assign m_is_end       = m_end_reg;
    assign m_status       = m_st_reg;
    assign m_freed_count  = m_freed_reg;

    // read data with forwarding of a same-cycle write
    assign eff = hit_reg ? wr_hold_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        wr_hold_reg <= wr_data;
    end

    always_comb begin
        state_next     = state_reg;
        fmt_next       = fmt_reg;
        kind_next      = kind_reg;
        blk_next       = blk_reg;
        blk_zero_next  = blk_zero_reg;
        blk_ok_next    = blk_ok_reg;
        cnt_next       = cnt_reg;
        freed_next     = freed_reg;
        cur_next       = cur_reg;
        scan_next      = scan_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        end_next       = end_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        m_res_next     = m_res_reg;
        m_end_next     = m_end_reg;
        m_st_next      = m_st_reg;
        m_freed_next   = m_freed_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = '0;
        rd_addr        = IDX_W'(s_block);
        walk_step      = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = (clr_reg == '0) ? LINK_END : '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_LAST) begin
                    clr_next   = '0;
                    state_next = fmt_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    kind_next     = s_kind;
                    blk_next      = IDX_W'(s_block);
                    blk_zero_next = (s_block == '0);
                    blk_ok_next   = (32'(s_block) < NUM_BLOCKS);
                    cnt_next      = s_block_count;
                    freed_next    = '0;
                    cur_next      = IDX_W'(s_block);
                    res_next      = '0;
                    end_next      = 1'b0;
                    st_next       = fcbm_pkg::ST_OK;
                    fmt_next      = (s_kind == fcbm_pkg::KIND_FORMAT);
                    state_next    = (s_kind == fcbm_pkg::KIND_FORMAT) ? S_CLEAR : S_CHECK;
                end
            end
            S_CHECK: begin
                case (kind_reg)
                    fcbm_pkg::KIND_ALLOC: begin
                        if (!blk_zero_reg && blk_ok_reg && eff == '0) begin
                            st_next    = fcbm_pkg::ST_BAD_BLK;
                            state_next = S_DONE;
                        end else if (!blk_ok_reg || blk_reg == IDX_LAST) begin
                            st_next    = fcbm_pkg::ST_NO_FREE;
                            state_next = S_DONE;
                        end else begin
                            scan_next  = blk_reg + 1'b1;
                            rd_addr    = blk_reg + 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    fcbm_pkg::KIND_FREE: begin
                        if (blk_zero_reg || !blk_ok_reg || eff == '0) begin
                            st_next    = fcbm_pkg::ST_BAD_BLK;
                            state_next = S_DONE;
                        end else begin
                            walk_step = 1'b1;
                        end
                    end
                    fcbm_pkg::KIND_NEXT: begin
                        if (!blk_ok_reg || eff == '0) begin
                            st_next = fcbm_pkg::ST_BAD_BLK;
                        end else if (eff == LINK_END) begin
                            end_next = 1'b1;
                        end else begin
                            res_next = fcbm_pkg::BLOCK_W'(eff);
                        end
                        state_next = S_DONE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (eff == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = scan_reg;
                    wr_data    = LINK_END;
                    res_next   = fcbm_pkg::BLOCK_W'(scan_reg);
                    state_next = blk_zero_reg ? S_DONE : S_LINK;
                end else if (scan_reg == IDX_LAST) begin
                    st_next    = fcbm_pkg::ST_NO_FREE;
                    state_next = S_DONE;
                end else begin
                    scan_next = scan_reg + 1'b1;
                    rd_addr   = scan_reg + 1'b1;
                end
            end
            S_LINK: begin
                wr_en      = 1'b1;
                wr_addr    = blk_reg;
                wr_data    = LINK_W'(scan_reg);
                state_next = S_DONE;
            end
            S_FWALK: begin
                walk_step = 1'b1;
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    m_res_next     = res_reg;
                    m_end_next     = end_reg;
                    m_st_next      = st_reg;
                    m_freed_next   = freed_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // one chain entry per cycle: clear cur, follow its link
        if (walk_step) begin
            if (freed_reg >= cnt_reg || eff == '0) begin
                state_next = S_DONE;
            end else begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg;
                wr_data    = '0;
                freed_next = freed_reg + 1'b1;
                if (eff >= LINK_END) begin
                    state_next = S_DONE;
                end else begin
                    cur_next   = IDX_W'(eff);
                    rd_addr    = IDX_W'(eff);
                    state_next = S_FWALK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            fmt_reg       <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fmt_reg       <= fmt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= wr_en && (wr_addr == rd_addr);
        end
        kind_reg     <= kind_next;
        blk_reg      <= blk_next;
        blk_zero_reg <= blk_zero_next;
        blk_ok_reg   <= blk_ok_next;
        cnt_reg      <= cnt_next;
        freed_reg    <= freed_next;
        cur_reg      <= cur_next;
        scan_reg     <= scan_next;
        res_reg      <= res_next;
        end_reg      <= end_next;
        st_reg       <= st_next;
        m_res_reg    <= m_res_next;
        m_end_reg    <= m_end_next;
        m_st_reg     <= m_st_next;
        m_freed_reg  <= m_freed_next;
    end

endmodule
